>>> design/aavr_pkg.sv
// Package for the axis-angle vector rotator: axis codes, control struct,
// CORDIC constants and the arctangent table. No dependencies.
`default_nettype none

package aavr_pkg;

	localparam int COORD_WIDTH_DEF   = 18;
	localparam int ANGLE_WIDTH_DEF   = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	localparam int TURN_WIDTH  = 32;
	localparam int GUARD_BITS  = 16;
	localparam int HEAD_BITS   = 2;
	localparam int KINV_FRAC   = 30;
	localparam int ATAN_DEPTH  = 24;

	localparam logic [KINV_FRAC-1:0]  KINV_Q30     = 30'd652032874;
	localparam logic [TURN_WIDTH-1:0] QUARTER_HALF = 32'h2000_0000;

	typedef enum logic [1:0] {
		AXIS_X    = 2'd0,
		AXIS_Y    = 2'd1,
		AXIS_Z    = 2'd2,
		AXIS_PASS = 2'd3
	} axis_t;

	typedef struct packed {
		logic  valid;
		axis_t axis;
	} ctl_t;

	// atan(2^-i) in 2^-32 turn units
	function automatic logic [TURN_WIDTH-1:0] atan_turn(input int idx);
		logic [TURN_WIDTH-1:0] v;
		begin
			unique case (idx)
				0:  v = 32'h2000_0000;
				1:  v = 32'h12E4_051D;
				2:  v = 32'h09FB_385B;
				3:  v = 32'h0511_11D4;
				4:  v = 32'h028B_0D43;
				5:  v = 32'h0145_D7E1;
				6:  v = 32'h00A2_F61E;
				7:  v = 32'h0051_7C55;
				8:  v = 32'h0028_BE53;
				9:  v = 32'h0014_5F2E;
				10: v = 32'h000A_2F98;
				11: v = 32'h0005_17CC;
				12: v = 32'h0002_8BE6;
				13: v = 32'h0001_45F3;
				14: v = 32'h0000_A2F9;
				15: v = 32'h0000_517D;
				16: v = 32'h0000_28BE;
				17: v = 32'h0000_145F;
				18: v = 32'h0000_0A2F;
				19: v = 32'h0000_0518;
				20: v = 32'h0000_028C;
				21: v = 32'h0000_0146;
				22: v = 32'h0000_00A3;
				23: v = 32'h0000_0051;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

endpackage

`default_nettype wire

>>> design/axis_angle_vector_rotator_unit.sv
// Top level of the axis-angle vector rotator: front end, chain of CORDIC
// cells and output stage. Uses aavr_pkg, aavr_prerot, aavr_cell, aavr_finish.
//
// Input channel: in_valid/in_ready carry axis, turn_angle and coord_x/y/z.
// Output channel: out_valid/out_ready carry rotated_x/y/z and saturated.
// One result per input transaction, in order.
// Path from input acceptance to out_valid: two front-end register stages,
// one register per CORDIC cell, then the output register.
// Throughput: one transaction per cycle unless the chain holds (see Stall);
// each cell handles one micro-rotation and passes its pair to the next.
// Stall: while a result waits at the output, the chain keeps moving until
// the last cell holds a result; only then does the whole chain, and in_ready,
// hold. in_ready is therefore low only while out_valid is high and
// out_ready low.
// Reset: arst_n clears all valid flags at once; no pending results survive
// and the block accepts input on the first cycle after reset.
`default_nettype none

module axis_angle_vector_rotator_unit import aavr_pkg::*; #(
	parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    axis,
	input  wire logic [ANGLE_WIDTH-1:0]        turn_angle,
	input  wire logic signed [COORD_WIDTH-1:0] coord_x,
	input  wire logic signed [COORD_WIDTH-1:0] coord_y,
	input  wire logic signed [COORD_WIDTH-1:0] coord_z,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0]      rotated_x,
	output logic signed [COORD_WIDTH-1:0]      rotated_y,
	output logic signed [COORD_WIDTH-1:0]      rotated_z,
	output logic                               saturated
);

	localparam int WORK_W = COORD_WIDTH + GUARD_BITS + HEAD_BITS;

	logic adv;
	ctl_t in_ctl;

	ctl_t                          ctl_c [0:CORDIC_STAGES];
	logic signed [WORK_W-1:0]      a_c   [0:CORDIC_STAGES];
	logic signed [WORK_W-1:0]      b_c   [0:CORDIC_STAGES];
	logic signed [TURN_WIDTH-1:0]  r_c   [0:CORDIC_STAGES];
	logic signed [COORD_WIDTH-1:0] x_c   [0:CORDIC_STAGES];
	logic signed [COORD_WIDTH-1:0] y_c   [0:CORDIC_STAGES];
	logic signed [COORD_WIDTH-1:0] z_c   [0:CORDIC_STAGES];

	assign in_ready     = adv;
	assign in_ctl.valid = in_valid;
	assign in_ctl.axis  = axis_t'(axis);

	aavr_prerot #(
		.COORD_WIDTH(COORD_WIDTH),
		.ANGLE_WIDTH(ANGLE_WIDTH)
	) u_prerot (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.ctl_in    (in_ctl),
		.turn_angle(turn_angle),
		.x_in      (coord_x),
		.y_in      (coord_y),
		.z_in      (coord_z),
		.ctl_out   (ctl_c[0]),
		.a_out     (a_c[0]),
		.b_out     (b_c[0]),
		.r_out     (r_c[0]),
		.x_out     (x_c[0]),
		.y_out     (y_c[0]),
		.z_out     (z_c[0])
	);

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		aavr_cell #(
			.COORD_WIDTH(COORD_WIDTH),
			.IDX        (i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (adv),
			.ctl_in(ctl_c[i]),
			.a_in  (a_c[i]),
			.b_in  (b_c[i]),
			.r_in  (r_c[i]),
			.x_in  (x_c[i]),
			.y_in  (y_c[i]),
			.z_in  (z_c[i]),
			.ctl_q (ctl_c[i+1]),
			.a_q   (a_c[i+1]),
			.b_q   (b_c[i+1]),
			.r_q   (r_c[i+1]),
			.x_q   (x_c[i+1]),
			.y_q   (y_c[i+1]),
			.z_q   (z_c[i+1])
		);
	end

	aavr_finish #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_finish (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (ctl_c[CORDIC_STAGES]),
		.a_in     (a_c[CORDIC_STAGES]),
		.b_in     (b_c[CORDIC_STAGES]),
		.x_in     (x_c[CORDIC_STAGES]),
		.y_in     (y_c[CORDIC_STAGES]),
		.z_in     (z_c[CORDIC_STAGES]),
		.adv      (adv),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.rotated_x(rotated_x),
		.rotated_y(rotated_y),
		.rotated_z(rotated_z),
		.saturated(saturated)
	);

`ifndef SYNTHESIS
	stall_only_on_block: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input held off without a blocked output");
`endif

endmodule

`default_nettype wire

>>> design/aavr_prerot.sv
// Front end: pair selection, gain compensation multiply, angle split into
// quadrant and residual, quadrant pre-rotation. Two register stages. Uses aavr_pkg.
`default_nettype none

module aavr_prerot import aavr_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire ctl_t                          ctl_in,
	input  wire logic [ANGLE_WIDTH-1:0]        turn_angle,
	input  wire logic signed [COORD_WIDTH-1:0] x_in,
	input  wire logic signed [COORD_WIDTH-1:0] y_in,
	input  wire logic signed [COORD_WIDTH-1:0] z_in,
	output ctl_t                               ctl_out,
	output logic signed [COORD_WIDTH+GUARD_BITS+HEAD_BITS-1:0] a_out,
	output logic signed [COORD_WIDTH+GUARD_BITS+HEAD_BITS-1:0] b_out,
	output logic signed [TURN_WIDTH-1:0]       r_out,
	output logic signed [COORD_WIDTH-1:0]      x_out,
	output logic signed [COORD_WIDTH-1:0]      y_out,
	output logic signed [COORD_WIDTH-1:0]      z_out
);

	localparam int WORK_W = COORD_WIDTH + GUARD_BITS + HEAD_BITS;
	localparam int PROD_W = COORD_WIDTH + KINV_FRAC + 1;
	localparam int SHIFT  = KINV_FRAC - GUARD_BITS;

	logic signed [COORD_WIDTH-1:0] sel_a, sel_b;
	logic signed [PROD_W-1:0]      prod_a, prod_b;
	logic [TURN_WIDTH-1:0]         u_ang, u_bias, r_raw;
	logic [1:0]                    quad;

	ctl_t                          ctl_s1;
	logic signed [PROD_W-1:0]      prod_a_s1, prod_b_s1;
	logic [1:0]                    quad_s1;
	logic [TURN_WIDTH-1:0]         r_s1;
	logic signed [COORD_WIDTH-1:0] x_s1, y_s1, z_s1;

	logic signed [WORK_W-1:0]      wa, wb, qa, qb;

	always_comb begin
		unique case (ctl_in.axis)
			AXIS_X: begin
				sel_a = z_in;
				sel_b = y_in;
			end
			AXIS_Y: begin
				sel_a = x_in;
				sel_b = z_in;
			end
			AXIS_Z, AXIS_PASS: begin
				sel_a = x_in;
				sel_b = y_in;
			end
			default: begin
				sel_a = x_in;
				sel_b = y_in;
			end
		endcase
	end

	assign prod_a = sel_a * $signed({1'b0, KINV_Q30});
	assign prod_b = sel_b * $signed({1'b0, KINV_Q30});

	assign u_ang  = {turn_angle, {(TURN_WIDTH-ANGLE_WIDTH){1'b0}}};
	assign u_bias = u_ang + QUARTER_HALF;
	assign quad   = u_bias[TURN_WIDTH-1:TURN_WIDTH-2];
	assign r_raw  = u_ang - {quad, {(TURN_WIDTH-2){1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_a_s1   <= prod_a;
			prod_b_s1   <= prod_b;
			quad_s1     <= quad;
			r_s1        <= r_raw;
			x_s1        <= x_in;
			y_s1        <= y_in;
			z_s1        <= z_in;
		end
	end

	assign wa = WORK_W'($signed(prod_a_s1[PROD_W-1:SHIFT]));
	assign wb = WORK_W'($signed(prod_b_s1[PROD_W-1:SHIFT]));

	always_comb begin
		unique case (quad_s1)
			2'd0: begin
				qa = wa;
				qb = wb;
			end
			2'd1: begin
				qa = -wb;
				qb = wa;
			end
			2'd2: begin
				qa = -wa;
				qb = -wb;
			end
			2'd3: begin
				qa = wb;
				qb = -wa;
			end
			default: begin
				qa = wa;
				qb = wb;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (en) begin
			ctl_out <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_out        <= qa;
			b_out        <= qb;
			r_out        <= $signed(r_s1);
			x_out        <= x_s1;
			y_out        <= y_s1;
			z_out        <= z_s1;
		end
	end

endmodule

`default_nettype wire

>>> design/aavr_cell.sv
// One CORDIC micro-rotation cell: fixed shift, one arctangent constant,
// one register stage. Uses aavr_pkg.
`default_nettype none

module aavr_cell import aavr_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int IDX         = 0
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire ctl_t                          ctl_in,
	input  wire logic signed [COORD_WIDTH+GUARD_BITS+HEAD_BITS-1:0] a_in,
	input  wire logic signed [COORD_WIDTH+GUARD_BITS+HEAD_BITS-1:0] b_in,
	input  wire logic signed [TURN_WIDTH-1:0]  r_in,
	input  wire logic signed [COORD_WIDTH-1:0] x_in,
	input  wire logic signed [COORD_WIDTH-1:0] y_in,
	input  wire logic signed [COORD_WIDTH-1:0] z_in,
	output ctl_t                               ctl_q,
	output logic signed [COORD_WIDTH+GUARD_BITS+HEAD_BITS-1:0] a_q,
	output logic signed [COORD_WIDTH+GUARD_BITS+HEAD_BITS-1:0] b_q,
	output logic signed [TURN_WIDTH-1:0]       r_q,
	output logic signed [COORD_WIDTH-1:0]      x_q,
	output logic signed [COORD_WIDTH-1:0]      y_q,
	output logic signed [COORD_WIDTH-1:0]      z_q
);

	localparam int WORK_W = COORD_WIDTH + GUARD_BITS + HEAD_BITS;
	localparam logic signed [TURN_WIDTH-1:0] ATAN_K = $signed(atan_turn(IDX));

	logic signed [WORK_W-1:0] da, db;

	assign da = b_in >>> IDX;
	assign db = a_in >>> IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q        <= x_in;
			y_q        <= y_in;
			z_q        <= z_in;
			if (!r_in[TURN_WIDTH-1]) begin
				a_q <= a_in - da;
				b_q <= b_in + db;
				r_q <= r_in - ATAN_K;
			end else begin
				a_q <= a_in + da;
				b_q <= b_in - db;
				r_q <= r_in + ATAN_K;
			end
		end
	end

`ifndef SYNTHESIS
	// gain-compensated magnitude never reaches the top headroom bit
	a_headroom: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.valid |-> (a_q[WORK_W-1] == a_q[WORK_W-2]) && (b_q[WORK_W-1] == b_q[WORK_W-2]))
		else $error("cordic working value overflow");
`endif

endmodule

`default_nettype wire

>>> design/aavr_finish.sv
// Back end: rounding, saturation, coordinate reassembly and the output
// register with its valid/ready handshake. Uses aavr_pkg.
`default_nettype none

module aavr_finish import aavr_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ctl_t                          ctl_in,
	input  wire logic signed [COORD_WIDTH+GUARD_BITS+HEAD_BITS-1:0] a_in,
	input  wire logic signed [COORD_WIDTH+GUARD_BITS+HEAD_BITS-1:0] b_in,
	input  wire logic signed [COORD_WIDTH-1:0] x_in,
	input  wire logic signed [COORD_WIDTH-1:0] y_in,
	input  wire logic signed [COORD_WIDTH-1:0] z_in,
	output logic                               adv,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0]      rotated_x,
	output logic signed [COORD_WIDTH-1:0]      rotated_y,
	output logic signed [COORD_WIDTH-1:0]      rotated_z,
	output logic                               saturated
);

	localparam int WORK_W = COORD_WIDTH + GUARD_BITS + HEAD_BITS;
	localparam int RND_W  = WORK_W - GUARD_BITS;
	localparam logic signed [WORK_W-1:0] ROUND_HALF = WORK_W'(1) <<< (GUARD_BITS - 1);
	localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	logic signed [WORK_W-1:0]      ra, rb;
	logic signed [RND_W-1:0]       va, vb;
	logic signed [COORD_WIDTH-1:0] fa, fb;
	logic                          ca, cb;
	logic signed [COORD_WIDTH-1:0] nx, ny, nz;
	logic                          nsat;
	logic                          load;

	assign ra = a_in + ROUND_HALF;
	assign rb = b_in + ROUND_HALF;
	assign va = ra[WORK_W-1:GUARD_BITS];
	assign vb = rb[WORK_W-1:GUARD_BITS];

	// fits when the bits above the coordinate's sign all match it
	assign ca = !((&va[RND_W-1:COORD_WIDTH-1]) || !(|va[RND_W-1:COORD_WIDTH-1]));
	assign cb = !((&vb[RND_W-1:COORD_WIDTH-1]) || !(|vb[RND_W-1:COORD_WIDTH-1]));
	assign fa = ca ? (va[RND_W-1] ? COORD_MIN : COORD_MAX) : va[COORD_WIDTH-1:0];
	assign fb = cb ? (vb[RND_W-1] ? COORD_MIN : COORD_MAX) : vb[COORD_WIDTH-1:0];

	always_comb begin
		unique case (ctl_in.axis)
			AXIS_X: begin
				nx   = x_in;
				ny   = fb;
				nz   = fa;
				nsat = ca | cb;
			end
			AXIS_Y: begin
				nx   = fa;
				ny   = y_in;
				nz   = fb;
				nsat = ca | cb;
			end
			AXIS_Z: begin
				nx   = fa;
				ny   = fb;
				nz   = z_in;
				nsat = ca | cb;
			end
			AXIS_PASS: begin
				nx   = x_in;
				ny   = y_in;
				nz   = z_in;
				nsat = 1'b0;
			end
			default: begin
				nx   = x_in;
				ny   = y_in;
				nz   = z_in;
				nsat = 1'b0;
			end
		endcase
	end

	// pipeline holds only when the last cell has a result and the output is blocked
	assign adv  = !(ctl_in.valid && out_valid && !out_ready);
	assign load = ctl_in.valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rotated_x <= nx;
			rotated_y <= ny;
			rotated_z <= nz;
			saturated <= nsat;
		end
	end

`ifndef SYNTHESIS
	pass_no_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(load && (ctl_in.axis == AXIS_PASS)) |=> !saturated)
		else $error("pass-through transaction flagged as saturated");
`endif

endmodule

`default_nettype wire

>>> tb/rotation_checker.sv
`timescale 1ns / 1ps
// Checker for axis_angle_vector_rotator_unit: watches both channels, predicts the
// rotated vector of every input transaction and compares results in order.
// Depends on aavr_pkg for widths, axis codes and CORDIC constants.

module rotation_checker import aavr_pkg::*; (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	input  wire logic                                in_ready,
	input  wire logic [1:0]                          axis,
	input  wire logic [ANGLE_WIDTH_DEF-1:0]          turn_angle,
	input  wire logic signed [COORD_WIDTH_DEF-1:0]   coord_x,
	input  wire logic signed [COORD_WIDTH_DEF-1:0]   coord_y,
	input  wire logic signed [COORD_WIDTH_DEF-1:0]   coord_z,
	input  wire logic                                out_valid,
	input  wire logic                                out_ready,
	input  wire logic signed [COORD_WIDTH_DEF-1:0]   rotated_x,
	input  wire logic signed [COORD_WIDTH_DEF-1:0]   rotated_y,
	input  wire logic signed [COORD_WIDTH_DEF-1:0]   rotated_z,
	input  wire logic                                saturated,
	output int                                       fail_count,
	output int                                       pending
);

	localparam int CW     = COORD_WIDTH_DEF;
	localparam int AW     = ANGLE_WIDTH_DEF;
	localparam int STAGES = (CORDIC_STAGES_DEF > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STAGES_DEF;

	// arctangent of 2^-i in 2^-32 turn units
	localparam logic [31:0] ARCTAN_STEP [0:23] = '{
		32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4,
		32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
		32'h0028_BE53, 32'h0014_5F2E, 32'h000A_2F98, 32'h0005_17CC,
		32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517D,
		32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0518,
		32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
	};

	typedef logic signed [CW-1:0] coord_t;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   sat;
	} rot_vec_t;

	rot_vec_t rotated_q[$];

	function automatic coord_t round_clip(input longint w, inout logic clip);
		longint v, hi, lo;
		hi = (longint'(1) << (CW - 1)) - 1;
		lo = -hi - 1;
		v = (w + (longint'(1) << (GUARD_BITS - 1))) >>> GUARD_BITS;
		if (v > hi) begin
			clip = 1'b1;
			v = hi;
		end else if (v < lo) begin
			clip = 1'b1;
			v = lo;
		end
		return v[CW-1:0];
	endfunction

	function automatic rot_vec_t rotate_vector(input axis_t ax, input logic [AW-1:0] ang,
			input coord_t x, input coord_t y, input coord_t z);
		rot_vec_t res;
		longint a, b, da, db, tmp, resid;
		logic [31:0] u, s, rr;
		logic [1:0] quad;
		coord_t na, nb;
		res.x = x;
		res.y = y;
		res.z = z;
		res.sat = 1'b0;
		if (ax == AXIS_PASS)
			return res;
		case (ax)
			AXIS_X: begin
				a = z;
				b = y;
			end
			AXIS_Y: begin
				a = x;
				b = z;
			end
			default: begin
				a = x;
				b = y;
			end
		endcase
		a = (a * longint'(KINV_Q30)) >>> (KINV_FRAC - GUARD_BITS);
		b = (b * longint'(KINV_Q30)) >>> (KINV_FRAC - GUARD_BITS);
		u = {ang, {(32 - AW){1'b0}}};
		s = u + 32'h2000_0000;
		quad = s[31:30];
		rr = u - {quad, 30'd0};
		resid = $signed(rr);
		case (quad)
			2'd1: begin
				tmp = a;
				a = -b;
				b = tmp;
			end
			2'd2: begin
				a = -a;
				b = -b;
			end
			2'd3: begin
				tmp = a;
				a = b;
				b = -tmp;
			end
			default: ;
		endcase
		for (int i = 0; i < STAGES; i++) begin
			da = b >>> i;
			db = a >>> i;
			if (resid >= 0) begin
				a = a - da;
				b = b + db;
				resid = resid - longint'(ARCTAN_STEP[i]);
			end else begin
				a = a + da;
				b = b - db;
				resid = resid + longint'(ARCTAN_STEP[i]);
			end
		end
		na = round_clip(a, res.sat);
		nb = round_clip(b, res.sat);
		case (ax)
			AXIS_X: begin
				res.z = na;
				res.y = nb;
			end
			AXIS_Y: begin
				res.x = na;
				res.z = nb;
			end
			default: begin
				res.x = na;
				res.y = nb;
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rot_vec_t want;
		if (!arst_n) begin
			rotated_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready)
				rotated_q.push_back(rotate_vector(axis_t'(axis), turn_angle,
					coord_x, coord_y, coord_z));
			if (out_valid && out_ready) begin
				if (rotated_q.size() == 0) begin
					$error("result transaction with no input pending");
					fail_count <= fail_count + 1;
				end else begin
					want = rotated_q.pop_front();
					if (rotated_x !== want.x || rotated_y !== want.y ||
							rotated_z !== want.z || saturated !== want.sat)
						fail_count <= fail_count + 1;
					if (rotated_x !== want.x)
						$error("rotated_x: expected %0d, got %0d", want.x, rotated_x);
					if (rotated_y !== want.y)
						$error("rotated_y: expected %0d, got %0d", want.y, rotated_y);
					if (rotated_z !== want.z)
						$error("rotated_z: expected %0d, got %0d", want.z, rotated_z);
					if (saturated !== want.sat)
						$error("saturated: expected %0b, got %0b", want.sat, saturated);
				end
			end
			pending <= rotated_q.size();
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the rotator testbench: clock, reset, directed and random vectors,
// random idling on both channels and the verdict. Uses aavr_pkg, rotation_checker.

module tb_top;
	import aavr_pkg::*;

	localparam int CW      = COORD_WIDTH_DEF;
	localparam int AW      = ANGLE_WIDTH_DEF;
	localparam int LATENCY = CORDIC_STAGES_DEF + 3;
	localparam int N_RAND  = 550;

	typedef logic signed [CW-1:0] coord_t;

	localparam coord_t C_MAX = {1'b0, {(CW - 1){1'b1}}};
	localparam coord_t C_MIN = {1'b1, {(CW - 1){1'b0}}};

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, saturated;
	logic [1:0] axis;
	logic [AW-1:0] turn_angle;
	coord_t coord_x, coord_y, coord_z, rotated_x, rotated_y, rotated_z;
	int fail_count, pending;
	int gap_pct, stall_pct;

	axis_angle_vector_rotator_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.axis       (axis),
		.turn_angle (turn_angle),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.coord_z    (coord_z),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.rotated_x  (rotated_x),
		.rotated_y  (rotated_y),
		.rotated_z  (rotated_z),
		.saturated  (saturated)
	);

	rotation_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.axis       (axis),
		.turn_angle (turn_angle),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.coord_z    (coord_z),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.rotated_x  (rotated_x),
		.rotated_y  (rotated_y),
		.rotated_z  (rotated_z),
		.saturated  (saturated),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#800000;
		$display("FAIL axis_angle_vector_rotator_unit");
		$finish;
	end

	// result side back-pressure
	initial begin
		int n;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 4);
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic send_vector(input axis_t ax, input logic [AW-1:0] ang,
			input coord_t x, input coord_t y, input coord_t z);
		int n;
		if ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			n = $urandom_range(1, 4);
			repeat (n) @(posedge clk);
		end
		in_valid   <= 1'b1;
		axis       <= ax;
		turn_angle <= ang;
		coord_x    <= x;
		coord_y    <= y;
		coord_z    <= z;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic coord_t rand_coord();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(0, 9))
			0: return C_MAX;
			1: return C_MIN;
			2: return coord_t'(int'($urandom_range(0, 64)) - 32);
			default: return r[CW-1:0];
		endcase
	endfunction

	function automatic logic [AW-1:0] rand_angle();
		logic [AW-1:0] base, d;
		if ($urandom_range(0, 3) != 0)
			return AW'($urandom_range(0, (1 << AW) - 1));
		base = AW'($urandom_range(0, 7) << (AW - 3));
		d = AW'($urandom_range(0, 4));
		return base + d - 2'd2;
	endfunction

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		axis       <= AXIS_PASS;
		turn_angle <= '0;
		coord_x    <= '0;
		coord_y    <= '0;
		coord_z    <= '0;
		gap_pct    = 25;
		stall_pct  = 25;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// pass-through, zero angle, quarter turns, octant edges, clipping
		send_vector(AXIS_PASS, 16'h1234, C_MAX, C_MIN, 18'sh15555);
		send_vector(AXIS_PASS, 16'hFFFF, '0, '0, '0);
		send_vector(AXIS_X, 16'h0000, 1000, -2000, 3000);
		send_vector(AXIS_Y, 16'h0000, 1000, -2000, 3000);
		send_vector(AXIS_Z, 16'h0000, C_MAX, C_MIN, 3000);
		send_vector(AXIS_X, 16'h4000, C_MIN, C_MAX, C_MIN);
		send_vector(AXIS_Y, 16'h4000, C_MAX, 77, C_MIN);
		send_vector(AXIS_Z, 16'h4000, C_MIN, C_MAX, -5);
		send_vector(AXIS_Z, 16'h8000, C_MIN, C_MIN, C_MAX);
		send_vector(AXIS_Y, 16'hC000, 50000, -1, -70000);
		send_vector(AXIS_X, 16'hFFFF, 12345, 100000, -100000);
		send_vector(AXIS_Z, 16'h2000, C_MAX, C_MAX, 0);
		send_vector(AXIS_Y, 16'h2000, C_MIN, 9, C_MIN);
		send_vector(AXIS_X, 16'h1FFF, 0, C_MAX, C_MIN);
		send_vector(AXIS_Z, 16'hE000, C_MIN, C_MAX, C_MAX);
		send_vector(AXIS_Z, 16'h3039, '0, '0, '0);
		send_vector(AXIS_X, 16'h6000, C_MAX, C_MAX, C_MAX);
		send_vector(AXIS_X, 16'h0001, 1, -1, 1);
		send_vector(AXIS_Y, 16'hA000, -1, -1, -1);
		send_vector(AXIS_Z, 16'h5FFF, 65536, -65536, 0);

		for (int k = 0; k < N_RAND; k++) begin
			if (k % 110 == 0) begin
				gap_pct   = 25 * $urandom_range(0, 2);
				stall_pct = 25 * $urandom_range(0, 2);
			end
			if (k >= N_RAND - 50) begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			send_vector(axis_t'($urandom_range(0, 3)), rand_angle(),
				rand_coord(), rand_coord(), rand_coord());
		end
		in_valid <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (LATENCY + 8) @(posedge clk);
		if (fail_count == 0)
			$display("PASS axis_angle_vector_rotator_unit");
		else
			$display("FAIL axis_angle_vector_rotator_unit");
		$finish;
	end

endmodule
